// ===== rtl/mmt_pkg.sv =====
package mmt_pkg;

  localparam int MAX_ROWS  = 8;
  localparam int MAX_COLS  = 8;
  localparam int MAX_INNER = 64;

  localparam int ROW_W   = 4;
  localparam int INNER_W = 7;
  localparam int COL_W   = 4;
  localparam int ELEM_W  = 16;
  localparam int SUM_W   = 38;
  localparam int PROD_W  = 32;

  localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int B_DEPTH = MAX_COLS * MAX_INNER;
  localparam int A_AW    = $clog2(A_DEPTH);
  localparam int B_AW    = $clog2(B_DEPTH);
  localparam int RIDX_W  = $clog2(MAX_ROWS);
  localparam int CIDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int KIDX_W  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int POS_W   = $clog2(A_DEPTH + B_DEPTH + 1);

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_INNER  = 2'd1;
  localparam logic [1:0] REG_COLS   = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_DRAIN} state_t;

  // one cell's control, travels down the chain with the data
  typedef struct packed {
    logic clear;
    logic acc;
    logic dump;
  } cell_ctl_t;

endpackage

// ===== rtl/mmt_mac_cell.sv =====
module mmt_mac_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  mmt_pkg::cell_ctl_t           ctl_in,
  input  logic signed [15:0]           a_in,
  input  logic signed [15:0]           b_own,
  input  logic                         shift,
  input  logic signed [37:0]           chain_in,
  output mmt_pkg::cell_ctl_t           ctl_out,
  output logic signed [15:0]           a_out,
  output logic signed [37:0]           chain_out
);
  import mmt_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_ok;
  logic                     prod_clear;
  logic                     dump_d;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  acc_next;

  always_comb begin
    acc_next = prod_clear ? SUM_W'(prod) : acc + SUM_W'(prod);
  end

  // stage 1: multiply, stage 2: accumulate; a is handed right each cycle
  always_ff @(posedge clk) begin
    prod       <= a_in * b_own;
    prod_clear <= ctl_in.clear;
    a_out      <= a_in;
    if (rst) begin
      prod_ok <= 1'b0;
      dump_d  <= 1'b0;
      ctl_out <= '0;
    end else begin
      prod_ok <= ctl_in.acc;
      dump_d  <= ctl_in.dump;
      ctl_out <= ctl_in;
    end
    if (prod_ok) acc <= acc_next;
    // load the finished sum on dump, shift toward cell 0 on shift, else hold
    if (dump_d)     chain_out <= acc_next;
    else if (shift) chain_out <= chain_in;
  end

endmodule

// ===== rtl/matrix_multiply_transposed.sv =====
// Channel  | Signals                              | Direction
// ---------+--------------------------------------+----------
// input    | valid_in, stall_in, element          | in / stall out
// output   | valid_out, stall_out, product_value, | out / stall in
//          | final_flag                           |
// config   | cfg_valid, cfg_ready, cfg_index,     | in / ready out
//          | cfg_data                             |
// Loading accepts one element per cycle unless stalled, (row_count +
// col_count) * inner_length elements in all. After the last element of B each
// row of A is swept through a chain of MAX_COLS MAC cells: inner_length issues
// (one A read a cycle), a wait for the last cell's sum, then col_count shifts,
// one result each. Input stalls during compute and drain and while a config
// write is offered. Reset is synchronous; the matrix memories are not cleared.
// A stall on the output holds the result register and the chain.
module matrix_multiply_transposed (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  output logic                        stall_in,
  input  logic signed [15:0]          element,
  output logic                        valid_out,
  input  logic                        stall_out,
  output logic signed [37:0]          product_value,
  output logic                        final_flag,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [7:0]                  cfg_data
);
  import mmt_pkg::*;

  logic [ROW_W-1:0]   row_reg;
  logic [INNER_W-1:0] inner_reg;
  logic [COL_W-1:0]   col_reg;
  logic [ROW_W-1:0]   rows;
  logic [INNER_W-1:0] dims;
  logic [COL_W-1:0]   cols;

  // clamp counts: zero acts as one, overflow saturates
  always_comb begin
    rows = (row_reg == '0) ? ROW_W'(1) :
           (row_reg > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : row_reg;
    dims = (inner_reg == '0) ? INNER_W'(1) :
           (inner_reg > INNER_W'(MAX_INNER)) ? INNER_W'(MAX_INNER) : inner_reg;
    cols = (col_reg == '0) ? COL_W'(1) :
           (col_reg > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS) : col_reg;
  end

  state_t state, state_next;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] a_len, total;
  logic [A_AW-1:0]  a_base;   // r*dims, walking row base
  logic [KIDX_W:0]  kcnt;     // element index within the row, 0 to dims - 1
  logic [ROW_W-1:0] rcnt;
  logic [COL_W:0]   dcnt;     // drain counter
  logic             row_last;

  assign a_len = POS_W'(rows * dims);
  assign total = a_len + POS_W'(cols * dims);

  // a config write takes the cycle; hold the element until it is done
  assign cfg_ready = (state == ST_LOAD);
  assign stall_in  = (state != ST_LOAD) || cfg_valid;

  logic acc_in;
  assign acc_in = valid_in && !stall_in;

  // A memory, B memory split per column bank so each cell reads its own row
  logic signed [15:0] a_mem [A_DEPTH];
  logic signed [15:0] b_mem [MAX_COLS][MAX_INNER];
  logic signed [15:0] a_rd;
  logic signed [15:0] b_rd [MAX_COLS];
  logic [CIDX_W:0]    b_col;
  logic [KIDX_W:0]    b_k;
  logic               issue;  // a memory read this cycle
  logic               issue_clear, issue_dump;

  // B position to column/element by stepping counters
  always_ff @(posedge clk) begin
    if (acc_in && pos < a_len) a_mem[A_AW'(pos)] <= element;
    if (acc_in && pos >= a_len)
      b_mem[CIDX_W'(b_col)][KIDX_W'(b_k)] <= element;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_col <= '0;
      b_k   <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index != REG_UNUSED) begin
      b_col <= '0;
      b_k   <= '0;
    end else if (acc_in && pos >= a_len) begin
      if (pos + 1'b1 == total) begin
        b_col <= '0;
        b_k   <= '0;
      end else if (b_k == (KIDX_W+1)'(dims) - 1'b1) begin
        b_k   <= '0;
        b_col <= b_col + 1'b1;
      end else begin
        b_k <= b_k + 1'b1;
      end
    end
  end

  // address issue and read
  always_ff @(posedge clk) begin
    a_rd <= a_mem[A_AW'(a_base + A_AW'(kcnt))];
  end

  // Wait for the last cell's sum to land in the chain before shifting.
  localparam int DUMP_LAT = MAX_COLS + 1;
  logic [$clog2(DUMP_LAT+1)-1:0] wcnt;
  logic                          out_full;
  logic                          shift;

  // skew: cell j sees a, control and its B element in the same cycle, after cell j-1
  cell_ctl_t          ctl_q;
  logic [KIDX_W-1:0]  k_pipe [MAX_COLS];
  cell_ctl_t          ctl_chain [MAX_COLS+1];
  logic signed [15:0] a_chain [MAX_COLS+1];
  logic signed [37:0] s_chain [MAX_COLS+1];

  always_ff @(posedge clk) begin
    if (rst) ctl_q <= '0;
    else     ctl_q <= '{clear: issue_clear, acc: issue, dump: issue_dump};
  end

  assign ctl_chain[0] = ctl_q;
  assign a_chain[0]   = a_rd;
  assign s_chain[MAX_COLS] = '0;

  genvar j;
  generate
    for (j = 0; j < MAX_COLS; j++) begin : g_cell
      if (j == 0) begin : g_k0
        assign k_pipe[j] = KIDX_W'(kcnt);
      end else begin : g_kn
        always_ff @(posedge clk) k_pipe[j] <= k_pipe[j-1];
      end
      always_ff @(posedge clk) b_rd[j] <= b_mem[j][k_pipe[j]];
      // each cell puts one register on a and control, matching the k_pipe step
      mmt_mac_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl_in   (ctl_chain[j]),
        .a_in     (a_chain[j]),
        .b_own    (b_rd[j]),
        .shift    (shift),
        .chain_in (s_chain[j+1]),
        .ctl_out  (ctl_chain[j+1]),
        .a_out    (a_chain[j+1]),
        .chain_out(s_chain[j])
      );
    end
  endgenerate

  always_comb begin
    state_next  = state;
    issue       = 1'b0;
    issue_clear = 1'b0;
    issue_dump  = 1'b0;
    row_last    = (kcnt == (KIDX_W+1)'(dims) - 1'b1);
    shift       = 1'b0;
    unique case (state)
      ST_LOAD: begin
        if (acc_in && pos + 1'b1 == total) state_next = ST_RUN;
      end
      ST_RUN: begin
        issue       = 1'b1;
        issue_clear = (kcnt == '0);
        issue_dump  = row_last;
        if (row_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        shift = (wcnt == '0) && (!out_full || !stall_out);
        if (shift && dcnt == (COL_W+1)'(cols) - 1'b1) begin
          state_next = (rcnt == rows - 1'b1) ? ST_LOAD : ST_RUN;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      pos      <= '0;
      kcnt     <= '0;
      rcnt     <= '0;
      dcnt     <= '0;
      a_base   <= '0;
      wcnt     <= '0;
      out_full <= 1'b0;
      row_reg  <= ROW_W'(MAX_ROWS);
      inner_reg<= INNER_W'(MAX_INNER);
      col_reg  <= COL_W'(MAX_COLS);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROWS:  row_reg   <= cfg_data[ROW_W-1:0];
          REG_INNER: inner_reg <= cfg_data[INNER_W-1:0];
          REG_COLS:  col_reg   <= cfg_data[COL_W-1:0];
          default: ;
        endcase
        if (cfg_index != REG_UNUSED) pos <= '0;
      end else if (acc_in) begin
        pos <= (pos + 1'b1 == total) ? '0 : pos + 1'b1;
      end
      if (state == ST_RUN) begin
        kcnt <= row_last ? '0 : kcnt + 1'b1;
        if (row_last) wcnt <= ($clog2(DUMP_LAT+1))'(DUMP_LAT);
      end else if (wcnt != '0) begin
        wcnt <= wcnt - 1'b1;
      end
      if (state == ST_LOAD) begin
        rcnt   <= '0;
        a_base <= '0;
        dcnt   <= '0;
      end
      if (shift) begin
        if (dcnt == (COL_W+1)'(cols) - 1'b1) begin
          dcnt   <= '0;
          rcnt   <= rcnt + 1'b1;
          a_base <= a_base + A_AW'(dims);
        end else begin
          dcnt <= dcnt + 1'b1;
        end
      end
      if (shift) out_full <= 1'b1;
      else if (!stall_out) out_full <= 1'b0;
    end
  end

  // chain is emptied from the near end: cell 0 holds the next column
  always_ff @(posedge clk) begin
    if (shift) begin
      product_value <= s_chain[0];
      final_flag    <= (rcnt == rows - 1'b1) && (dcnt == (COL_W+1)'(cols) - 1'b1);
    end
  end

  assign valid_out = out_full;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import mmt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid_in = 1'b0;
  logic stall_in;
  logic signed [15:0] element = '0;
  logic valid_out;
  logic stall_out = 1'b0;
  logic signed [37:0] product_value;
  logic final_flag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_ROWS;
  logic [7:0] cfg_data = '0;

  matrix_multiply_transposed dut (.*);

  always #6 clk = ~clk;

  typedef struct {
    logic signed [37:0] value;
    logic               last;
  } product_t;

  // predictor state
  logic [15:0] a_store [A_DEPTH];
  logic [15:0] b_store [B_DEPTH];
  int unsigned load_pos;
  int unsigned rows_reg, inner_reg, cols_reg;

  product_t expected_products[$];
  int  fail_count;
  bit  idle_allowed;
  int  stuck_cycles;
  int  items_sent;
  int  stall_left;

  function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Fold one element into the load; emit the product matrix when B is complete.
  function automatic void predict_element(logic [15:0] e);
    int unsigned rows, dims, cols, a_len, total, pos;
    logic signed [37:0] sum;
    product_t p;
    rows = clamp_count(rows_reg, MAX_ROWS);
    dims = clamp_count(inner_reg, MAX_INNER);
    cols = clamp_count(cols_reg, MAX_COLS);
    a_len = rows * dims;
    total = a_len + cols * dims;
    pos = load_pos;
    if (pos >= total) pos = 0;
    if (pos < a_len) a_store[pos] = e;
    else b_store[pos - a_len] = e;
    pos++;
    if (pos < total) begin
      load_pos = pos;
      return;
    end
    load_pos = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        sum = '0;
        for (int k = 0; k < dims; k++)
          sum += 38'(signed'(a_store[r * dims + k]) * signed'(b_store[c * dims + k]));
        p.value = sum;
        p.last = (r == rows - 1) && (c == cols - 1);
        expected_products.push_back(p);
      end
    end
  endfunction

  // Write one register; block must be idle when called.
  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROWS: begin
        rows_reg = data & 8'hF;
        load_pos = 0;
      end
      REG_INNER: begin
        inner_reg = data & 8'h7F;
        load_pos = 0;
      end
      REG_COLS: begin
        cols_reg = data & 8'hF;
        load_pos = 0;
      end
      default: ;
    endcase
  endtask

  // Send one element, with an optional random gap first.
  task automatic send_element(logic [15:0] e);
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      valid_in <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    valid_in <= 1'b1;
    element  <= e;
    do @(posedge clk); while (stall_in);
    predict_element(e);
    items_sent++;
  endtask

  task automatic release_input();
    valid_in <= 1'b0;
  endtask

  // Wait until all products are out, plus pipeline slack.
  task automatic drain();
    release_input();
    while (expected_products.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(int unsigned rows, int unsigned dims, int unsigned cols);
    write_reg(REG_ROWS, 8'(rows));
    write_reg(REG_INNER, 8'(dims));
    write_reg(REG_COLS, 8'(cols));
  endtask

  function automatic logic [15:0] random_element();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic load_random_matrices(int unsigned rows, int unsigned dims,
                                      int unsigned cols);
    for (int i = 0; i < (rows + cols) * dims; i++) send_element(random_element());
  endtask

  // Directed: extremes of the element, 1x1x1, zero and saturated counts.
  task automatic test_directed();
    configure(1, 1, 1);
    send_element(16'h8000); send_element(16'h8000);   // largest positive product
    send_element(16'h7FFF); send_element(16'h8000);   // most negative product
    send_element(16'hFFFF); send_element(16'h0001);
    send_element(16'h0000); send_element(16'h7FFF);
    drain();
    // zero counts act as one
    configure(0, 0, 0);
    send_element(16'h5A5A); send_element(16'hA5A5);
    drain();
    // counts above the maximum saturate; one load with every term extreme
    configure(15, 2, 15);
    for (int i = 0; i < 32; i++) send_element((i % 3 == 0) ? 16'h7FFF : 16'h8000);
    drain();
    // full inner length, tiny matrices; every element negative extreme, largest positive sum
    configure(1, 127, 1);
    for (int i = 0; i < 128; i++) send_element(16'h8000);
    drain();
  endtask

  // A write to a count register restarts the load midway; one beyond the list does not.
  task automatic test_restart();
    configure(2, 3, 2);
    for (int i = 0; i < 5; i++) send_element(random_element());
    drain();
    write_reg(REG_INNER, 8'd3);
    load_random_matrices(2, 3, 2);
    drain();
    // a write beyond the register list leaves a partial load intact
    for (int i = 0; i < 5; i++) send_element(random_element());
    release_input();
    write_reg(REG_UNUSED, 8'hFF);
    for (int i = 0; i < 7; i++) send_element(random_element());
    drain();
  endtask

  // Random sizes, mostly small; shrink the inner length to fit the budget.
  task automatic test_random(int unsigned budget);
    int unsigned rows, dims, cols;
    while (items_sent < budget) begin
      rows = $urandom_range(1, 4);
      dims = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
      cols = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) rows = 8;
      if ($urandom_range(0, 9) == 0) cols = 8;
      while ((rows + cols) * dims > budget - items_sent && dims > 1) dims--;
      configure(rows, dims, cols);
      load_random_matrices(rows, dims, cols);
      drain();
    end
  endtask

  // Output side: random stall bursts while allowed.
  always @(posedge clk) begin
    if (rst || !idle_allowed) begin
      stall_out  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) stall_out <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_out  <= 1'b1;
      stall_left <= $urandom_range(1, 5);
    end
  end

  // Compare each accepted product with the oldest expectation.
  always @(posedge clk) begin
    product_t want;
    if (!rst && valid_out && !stall_out) begin
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected product value=%0d final=%0b",
                 $time, product_value, final_flag);
        fail_count++;
      end else begin
        want = expected_products.pop_front();
        if (product_value !== want.value) begin
          $display("%0t: product_value expected %0d actual %0d",
                   $time, want.value, product_value);
          fail_count++;
        end
        if (final_flag !== want.last) begin
          $display("%0t: final_flag expected %0b actual %0b",
                   $time, want.last, final_flag);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on any channel.
  always @(posedge clk) begin
    if (rst || (valid_in && !stall_in) || (valid_out && !stall_out) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles > 20000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    fail_count = 0;
    items_sent = 0;
    idle_allowed = 1'b1;
    load_pos = 0;
    rows_reg = 8; inner_reg = 64; cols_reg = 8;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_restart();
    test_random(260);
    // no idling for the tail of the run
    idle_allowed = 1'b0;
    test_random(330);
    drain();
    if (fail_count == 0 && expected_products.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mmt_pkg.sv
rtl/mmt_mac_cell.sv
rtl/matrix_multiply_transposed.sv
sim/tb.sv
